### hdl/tbfc_pkg.sv
package tbfc_pkg;

  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REF = 16'h8408;  // 0x1021 bit-reversed
  localparam int          MIN_FRAME    = 6;
  localparam int          BYTE_BITS    = 8;
  localparam int          COUNT_W      = 11;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  // CRC-16/X-25 update, LSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REF;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/token_bus_frame_checker_unit.sv
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_stall     | data_byte, end_of_frame
// result   | out       | result_valid / result_stall | result_kind, payload_byte, frame_ok,
//          |           |                             | station_address, control_byte,
//          |           |                             | payload_count
// One byte per clock while item_stall is low: the byte-wide CRC update and frame
// state sit between the input handshake and one result register (result in next cycle).
// Synchronous active-high reset clears frame state and result_valid, not the result fields.
// item_stall is high only while a result is held and result_stall is high; a byte
// that yields no result still waits for that, as the result register is shared.
module token_bus_frame_checker_unit #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_frame,
  output logic                        result_valid,
  input  logic                        result_stall,
  output tbfc_pkg::result_kind_t      result_kind,
  output logic [7:0]                  payload_byte,
  output logic                        frame_ok,
  output logic [7:0]                  station_address,
  output logic [7:0]                  control_byte,
  output logic [tbfc_pkg::COUNT_W-1:0] payload_count
);
  import tbfc_pkg::*;

  localparam int LIMIT = MAX_PAYLOAD + MIN_FRAME;
  localparam int POS_W = $clog2(LIMIT + 1);
  localparam int LEN_W = POS_W + 1;

  localparam logic [POS_W-1:0] LIMIT_P   = POS_W'(LIMIT);
  localparam logic [LEN_W-1:0] MIN_L     = LEN_W'(MIN_FRAME);
  localparam logic [LEN_W-1:0] MAX_PAY_L = LEN_W'(MAX_PAYLOAD);
  localparam logic [POS_W-1:0] POS_ADDR  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CTRL  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CRC   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_REL   = POS_W'(5);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       delay0, delay1;   // newest first
  logic [15:0]      crc_register, crc_register_next;
  logic             opening_flag_seen, opening_flag_seen_next;
  logic [7:0]       saved_address, saved_address_next;
  logic [7:0]       saved_control, saved_control_next;
  logic             overlong, overlong_next;

  logic             take;
  logic             overlong_now;
  logic [LEN_W-1:0] frame_len, cnt;
  logic [15:0]      crc_got, crc_want;
  logic             ok;
  logic             emit;

  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  always_comb begin
    overlong_now           = overlong || (byte_position >= LIMIT_P);
    frame_len              = LEN_W'(byte_position) + LEN_W'(1);
    crc_got                = {delay0, delay1};
    crc_want               = crc_register ^ CRC_XOROUT;
    saved_address_next     = saved_address;
    saved_control_next     = saved_control;
    opening_flag_seen_next = opening_flag_seen;
    if (byte_position == '0) begin
      opening_flag_seen_next = (data_byte == FLAG_BYTE);
    end else if (byte_position == POS_ADDR) begin
      saved_address_next = data_byte;
    end else if (byte_position == POS_CTRL) begin
      saved_control_next = data_byte;
    end
    ok = !overlong_now && (frame_len >= MIN_L) && opening_flag_seen_next
         && (data_byte == FLAG_BYTE) && (crc_got == crc_want);
    cnt = (frame_len >= MIN_L) ? frame_len - MIN_L : '0;
    if (overlong_now || cnt > MAX_PAY_L) begin
      cnt = MAX_PAY_L;
    end
    if (end_of_frame) begin
      byte_position_next     = '0;
      crc_register_next      = CRC_INIT;
      opening_flag_seen_next = 1'b0;
      overlong_next          = 1'b0;
      emit                   = 1'b1;
    end else begin
      // byte two back is now known to be address, control or payload
      crc_register_next  = (byte_position >= POS_CRC) ? crc_byte(crc_register, delay1)
                                                      : crc_register;
      byte_position_next = (byte_position < LIMIT_P) ? byte_position + POS_W'(1)
                                                     : byte_position;
      overlong_next      = overlong_now;
      emit               = (byte_position >= POS_REL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      delay0            <= '0;
      delay1            <= '0;
      crc_register      <= CRC_INIT;
      opening_flag_seen <= 1'b0;
      saved_address     <= '0;
      saved_control     <= '0;
      overlong          <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (take) begin
        byte_position     <= byte_position_next;
        delay0            <= data_byte;
        delay1            <= delay0;
        crc_register      <= crc_register_next;
        opening_flag_seen <= opening_flag_seen_next;
        saved_address     <= saved_address_next;
        saved_control     <= saved_control_next;
        overlong          <= overlong_next;
        result_valid      <= emit;
      end
    end
  end

  // result payload, loaded on every transfer that yields a result
  always_ff @(posedge clk) begin
    if (take && emit) begin
      if (end_of_frame) begin
        result_kind     <= KIND_VERDICT;
        payload_byte    <= '0;
        frame_ok        <= ok;
        station_address <= ok ? saved_address_next : 8'h00;
        control_byte    <= ok ? saved_control_next : 8'h00;
        payload_count   <= COUNT_W'(cnt);
      end else begin
        result_kind     <= KIND_PAYLOAD;
        payload_byte    <= delay1;
        frame_ok        <= 1'b0;
        station_address <= '0;
        control_byte    <= '0;
        payload_count   <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_verdict_out: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_frame) |=> (result_valid && result_kind == KIND_VERDICT))
    else $error("final byte gave no verdict");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_frame) |=> (byte_position == '0 && crc_register == CRC_INIT
                                && !overlong && !opening_flag_seen))
    else $error("frame state not restarted after verdict");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_PAYLOAD) |-> (!frame_ok && payload_count == '0))
    else $error("payload result carries verdict fields");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LIMIT_P)
    else $error("byte position past frame limit");

  a_no_early_release: assert property (@(posedge clk) disable iff (rst)
    (take && !end_of_frame && byte_position < POS_REL) |=> !result_valid)
    else $error("header byte released as payload");
`endif

endmodule

### tb/sv/tb_token_bus_frame_checker_unit.sv
`timescale 1ns / 1ps

module tb_token_bus_frame_checker_unit;
  import tbfc_pkg::*;

  localparam int MAX_PAYLOAD = 1024;
  localparam int FRAME_CAP   = MAX_PAYLOAD + MIN_FRAME;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } rx_byte_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [7:0]           pbyte;
    logic                 ok;
    logic [7:0]           addr;
    logic [7:0]           ctl;
    logic [COUNT_W-1:0]   cnt;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [7:0]          data_byte = 8'h00;
  logic                end_of_frame = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_kind_t        result_kind;
  logic [7:0]          payload_byte;
  logic                frame_ok;
  logic [7:0]          station_address;
  logic [7:0]          control_byte;
  logic [COUNT_W-1:0]  payload_count;

  rx_byte_t    rx_stream[$];
  outcome_t    expected_results[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatch_count = 0;
  int          send_idle_pct = 19;
  int          recv_idle_pct = 60;

  // frame tracker state
  int unsigned pos = 0;
  logic [7:0]  hist0 = 8'h00;  // newest byte
  logic [7:0]  hist1 = 8'h00;
  logic [15:0] crc_acc = CRC_INIT;
  logic        open_ok = 1'b0;
  logic [7:0]  addr_q = 8'h00;
  logic [7:0]  ctl_q = 8'h00;
  logic        too_long = 1'b0;

  token_bus_frame_checker_unit #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .data_byte(data_byte),
    .end_of_frame(end_of_frame),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_kind(result_kind),
    .payload_byte(payload_byte),
    .frame_ok(frame_ok),
    .station_address(station_address),
    .control_byte(control_byte),
    .payload_count(payload_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // reflected CRC-16, one bit at a time
  function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < BYTE_BITS; i++) begin
      fb = r[0] ^ d[i];
      r = r >> 1;
      if (fb) r = r ^ CRC_POLY_REF;
    end
    return r;
  endfunction

  task automatic track_byte(input logic [7:0] d, input logic eof);
    outcome_t    e;
    int unsigned len;
    int unsigned cnt;
    logic        good;
    e.kind  = KIND_PAYLOAD;
    e.pbyte = 8'h00;
    e.ok    = 1'b0;
    e.addr  = 8'h00;
    e.ctl   = 8'h00;
    e.cnt   = '0;
    if (pos >= FRAME_CAP) too_long = 1'b1;
    if (pos == 0) open_ok = (d == FLAG_BYTE);
    else if (pos == 1) addr_q = d;
    else if (pos == 2) ctl_q = d;
    if (eof) begin
      len  = pos + 1;
      good = !too_long && len >= MIN_FRAME && open_ok && d == FLAG_BYTE
             && {hist0, hist1} == (crc_acc ^ CRC_XOROUT);
      cnt  = (len >= MIN_FRAME) ? len - MIN_FRAME : 0;
      if (too_long || cnt > MAX_PAYLOAD) cnt = MAX_PAYLOAD;
      e.kind = KIND_VERDICT;
      e.ok   = good;
      e.addr = good ? addr_q : 8'h00;
      e.ctl  = good ? ctl_q : 8'h00;
      e.cnt  = cnt[COUNT_W-1:0];
      expected_results.push_back(e);
      pos      = 0;
      crc_acc  = CRC_INIT;
      open_ok  = 1'b0;
      too_long = 1'b0;
    end else begin
      // byte two back is now known to be address, control or payload
      if (pos >= 3) crc_acc = crc_update(crc_acc, hist1);
      if (pos >= 5) begin
        e.pbyte = hist1;
        expected_results.push_back(e);
      end
      if (pos < FRAME_CAP) pos = pos + 1;
    end
    hist1 = hist0;
    hist0 = d;
  endtask

  task automatic push_byte(input logic [7:0] d, input logic eof);
    rx_byte_t b;
    b.data = d;
    b.eof  = eof;
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [7:0] open_flag, input logic [7:0] addr,
                            input logic [7:0] ctl, input int paylen,
                            input logic [7:0] close_flag, input logic [15:0] crc_flip);
    logic [15:0] fcs;
    logic [7:0]  d;
    fcs = CRC_INIT;
    push_byte(open_flag, 1'b0);
    push_byte(addr, 1'b0);
    fcs = crc_update(fcs, addr);
    push_byte(ctl, 1'b0);
    fcs = crc_update(fcs, ctl);
    for (int i = 0; i < paylen; i++) begin
      d = 8'($urandom);
      push_byte(d, 1'b0);
      fcs = crc_update(fcs, d);
    end
    fcs = fcs ^ CRC_XOROUT ^ crc_flip;
    push_byte(fcs[7:0], 1'b0);
    push_byte(fcs[15:8], 1'b0);
    push_byte(close_flag, 1'b1);
  endtask

  function automatic logic [7:0] wrong_flag();
    logic [7:0] d;
    d = 8'($urandom);
    if (d == FLAG_BYTE) d = d ^ 8'h01;
    return d;
  endfunction

  task automatic load_random(input int unsigned target);
    int unsigned start;
    int          sel;
    int          paylen;
    int          n;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      sel    = $urandom_range(99);
      paylen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
      if (sel < 65) begin
        push_frame(FLAG_BYTE, 8'($urandom), 8'($urandom), paylen, FLAG_BYTE, 16'h0000);
      end else if (sel < 73) begin
        push_frame(FLAG_BYTE, 8'($urandom), 8'($urandom), paylen, FLAG_BYTE,
                   16'h0001 << $urandom_range(15));
      end else if (sel < 78) begin
        push_frame(wrong_flag(), 8'($urandom), 8'($urandom), paylen, FLAG_BYTE, 16'h0000);
      end else if (sel < 83) begin
        push_frame(FLAG_BYTE, 8'($urandom), 8'($urandom), paylen, wrong_flag(), 16'h0000);
      end else if (sel < 90) begin
        // short frame
        n = $urandom_range(1, 5);
        push_byte(FLAG_BYTE, n == 1);
        for (int i = 1; i < n; i++) push_byte(8'($urandom), i == n - 1);
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (rx_stream.size() != 0 || item_valid || expected_results.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    rx_byte_t b;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) track_byte(data_byte, end_of_frame);
      if (!item_valid || !item_stall) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          b = rx_stream.pop_front();
          item_valid   <= 1'b1;
          data_byte    <= b.data;
          end_of_frame <= b.eof;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    outcome_t a;
    if (!rst && result_valid && !result_stall) begin
      a.kind  = result_kind;
      a.pbyte = payload_byte;
      a.ok    = frame_ok;
      a.addr  = station_address;
      a.ctl   = control_byte;
      a.cnt   = payload_count;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
          $display({"%0t: mismatch exp none",
                    " got kind=%0d byte=%h ok=%b addr=%h ctl=%h cnt=%0d"},
                   $time, a.kind, a.pbyte, a.ok, a.addr, a.ctl, a.cnt);
      end else begin
        e = expected_results.pop_front();
        if (a.kind !== e.kind || a.pbyte !== e.pbyte || a.ok !== e.ok
            || a.addr !== e.addr || a.ctl !== e.ctl || a.cnt !== e.cnt) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display({"%0t: mismatch exp kind=%0d byte=%h ok=%b addr=%h ctl=%h cnt=%0d",
                      " got kind=%0d byte=%h ok=%b addr=%h ctl=%h cnt=%0d"},
                     $time, e.kind, e.pbyte, e.ok, e.addr, e.ctl, e.cnt,
                     a.kind, a.pbyte, a.ok, a.addr, a.ctl, a.cnt);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    push_frame(FLAG_BYTE, 8'h00, 8'hFF, 0, FLAG_BYTE, 16'h0000);
    push_frame(FLAG_BYTE, 8'hFF, 8'h00, 1, FLAG_BYTE, 16'h0000);
    push_byte(FLAG_BYTE, 1'b1);
    push_byte(FLAG_BYTE, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(FLAG_BYTE, 1'b1);
    push_frame(FLAG_BYTE, FLAG_BYTE, FLAG_BYTE, 0, FLAG_BYTE, 16'h8001);
    load_random(130);
    drain();
    send_idle_pct = 60;
    recv_idle_pct = 19;
    load_random(130);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random(110);
    // one byte past the size limit: bad verdict, saturated count
    push_frame(FLAG_BYTE, 8'($urandom), 8'($urandom), MAX_PAYLOAD + 1, FLAG_BYTE,
               16'h0000);
    load_random(30);
    drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
